### rtl/gtg_pkg.sv
package gtg_pkg;

    // CORDIC datapath width: a 33-bit offset, one extra bit for negation,
    // and two more bits for the CORDIC gain.
    localparam int CW = 36;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int CORDIC_STAGES = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;

    localparam logic [23:0] INV_GAIN_Q24      = 24'd10188014;
    localparam logic [17:0] PI_Q16            = 18'd205887;
    localparam logic [15:0] MIN_LINEAR_SPEED  = 16'd1638;
    localparam logic [14:0] MIN_ANGULAR_SPEED = 15'd328;

    // Configuration register indexes.
    localparam logic [2:0] REG_TARGET_X          = 3'd0;
    localparam logic [2:0] REG_TARGET_Y          = 3'd1;
    localparam logic [2:0] REG_GOAL_TOLERANCE    = 3'd2;
    localparam logic [2:0] REG_HEADING_TOLERANCE = 3'd3;
    localparam logic [2:0] REG_DISTANCE_GAIN     = 3'd4;
    localparam logic [2:0] REG_YAW_GAIN          = 3'd5;
    localparam logic [2:0] REG_MAX_LINEAR        = 3'd6;
    localparam logic [2:0] REG_MAX_ANGULAR       = 3'd7;

    // Drive modes.
    localparam logic [1:0] MODE_TURN    = 2'd0;
    localparam logic [1:0] MODE_DRIVE   = 2'd1;
    localparam logic [1:0] MODE_ARRIVED = 2'd2;

    // Payload handed from one CORDIC cell to the next.
    typedef struct packed {
        logic                 zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          z;
        logic [15:0]          yaw;
    } t_cordic;

    // Settings used by the output stages.
    typedef struct packed {
        logic [15:0] goal_tolerance;
        logic [14:0] heading_tolerance;
        logic [15:0] distance_gain;
        logic [15:0] yaw_gain;
        logic [15:0] max_linear;
        logic [14:0] max_angular;
    } t_cfg;

    // Arctangent of 2^-i, with 2^32 standing for a full turn.
    function automatic logic [31:0] f_atan(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### rtl/go_to_goal_rotate_then_drive.sv
// From an accepted pose item to its result the pipeline holds 2 offset stages,
// one CORDIC cell per iteration and 5 scaling and clamping stages.
// Throughput: one item per cycle; every stage is a register and items do not
// depend on one another, so the pipeline is full when neither side stalls.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
module go_to_goal_rotate_then_drive (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic signed [15:0] i_pose_yaw,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_drive_mode,
    output logic [15:0]        o_linear_speed,
    output logic signed [15:0] o_angular_speed,
    output logic [31:0]        o_goal_distance,
    output logic signed [15:0] o_heading_error
);

    localparam int N = gtg_pkg::CORDIC_STAGES;

    logic signed [31:0] r_target_x;
    logic signed [31:0] r_target_y;
    gtg_pkg::t_cfg      r_cfg;

    gtg_pkg::t_cordic   w_d   [0:N];
    logic               w_v   [0:N];
    logic               w_rdy [0:N];
    logic               w_front_rdy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x              <= '0;
            r_target_y              <= '0;
            r_cfg.goal_tolerance    <= 16'd1638;
            r_cfg.heading_tolerance <= 15'd365;
            r_cfg.distance_gain     <= 16'd115;
            r_cfg.yaw_gain          <= 16'd384;
            r_cfg.max_linear        <= 16'd11796;
            r_cfg.max_angular       <= 15'd3277;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gtg_pkg::REG_TARGET_X:          r_target_x <= i_cfg_data;
                gtg_pkg::REG_TARGET_Y:          r_target_y <= i_cfg_data;
                gtg_pkg::REG_GOAL_TOLERANCE:    r_cfg.goal_tolerance <= i_cfg_data[15:0];
                gtg_pkg::REG_HEADING_TOLERANCE: r_cfg.heading_tolerance <= i_cfg_data[14:0];
                gtg_pkg::REG_DISTANCE_GAIN:     r_cfg.distance_gain <= i_cfg_data[15:0];
                gtg_pkg::REG_YAW_GAIN:          r_cfg.yaw_gain <= i_cfg_data[15:0];
                gtg_pkg::REG_MAX_LINEAR:        r_cfg.max_linear <= i_cfg_data[15:0];
                gtg_pkg::REG_MAX_ANGULAR:       r_cfg.max_angular <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign o_stall = !w_front_rdy;

    // Offset and half-plane fold.
    gtg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_rdy      (w_front_rdy),
        .i_target_x (r_target_x),
        .i_target_y (r_target_y),
        .i_pose_x   (i_pose_x),
        .i_pose_y   (i_pose_y),
        .i_pose_yaw (i_pose_yaw),
        .o_valid    (w_v[0]),
        .o_d        (w_d[0]),
        .i_rdy_next (w_rdy[0])
    );

    // Row of CORDIC cells, one iteration each.
    for (genvar g = 0; g < N; g++) begin : g_cell
        gtg_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (5'(g)),
            .i_valid    (w_v[g]),
            .i_d        (w_d[g]),
            .o_rdy      (w_rdy[g]),
            .o_valid    (w_v[g+1]),
            .o_d        (w_d[g+1]),
            .i_rdy_next (w_rdy[g+1])
        );
    end

    // Scaling, speed laws and output register.
    gtg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (w_v[N]),
        .i_d             (w_d[N]),
        .o_rdy           (w_rdy[N]),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_drive_mode    (o_drive_mode),
        .o_linear_speed  (o_linear_speed),
        .o_angular_speed (o_angular_speed),
        .o_goal_distance (o_goal_distance),
        .o_heading_error (o_heading_error)
    );

    // The pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A result that is not taken stays presented.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");

    // The mode code is always a defined one.
    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_drive_mode == gtg_pkg::MODE_TURN || o_drive_mode == gtg_pkg::MODE_DRIVE
                     || o_drive_mode == gtg_pkg::MODE_ARRIVED))
        else $error("undefined drive mode");

endmodule

### rtl/gtg_front.sv
module gtg_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_rdy,
    input  logic signed [31:0]   i_target_x,
    input  logic signed [31:0]   i_target_y,
    input  logic signed [31:0]   i_pose_x,
    input  logic signed [31:0]   i_pose_y,
    input  logic signed [15:0]   i_pose_yaw,
    output logic                 o_valid,
    output gtg_pkg::t_cordic     o_d,
    input  logic                 i_rdy_next
);

    logic                r_va;
    logic                r_vb;
    logic signed [32:0]  r_dx;
    logic signed [32:0]  r_dy;
    logic [15:0]         r_yaw;
    gtg_pkg::t_cordic    r_d;
    logic                w_rdy_a;
    logic                w_rdy_b;
    logic signed [32:0]  n_dx;
    logic signed [32:0]  n_dy;
    gtg_pkg::t_cordic    n_d;

    // Each stage loads when it is empty or its content moves on.
    assign w_rdy_b = !r_vb || i_rdy_next;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_rdy   = w_rdy_a;
    assign o_valid = r_vb;
    assign o_d     = r_d;

    // First stage: exact 33-bit offsets from the pose to the target.
    assign n_dx = 33'(i_target_x) - 33'(i_pose_x);
    assign n_dy = 33'(i_target_y) - 33'(i_pose_y);

    // Second stage: fold the vector into the right half plane.
    always_comb begin
        n_d.zero = (r_dx == '0) && (r_dy == '0);
        n_d.yaw  = r_yaw;
        if (r_dx[32]) begin
            n_d.x = -gtg_pkg::CW'(r_dx);
            n_d.y = -gtg_pkg::CW'(r_dy);
            n_d.z = 32'h80000000;
        end else begin
            n_d.x = gtg_pkg::CW'(r_dx);
            n_d.y = gtg_pkg::CW'(r_dy);
            n_d.z = 32'h00000000;
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_va <= i_valid;
            end
            if (w_rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_yaw <= i_pose_yaw;
        end
        if (w_rdy_b) begin
            r_d <= n_d;
        end
    end

endmodule

### rtl/gtg_cell.sv
module gtg_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [4:0]        i_shift,
    input  logic              i_valid,
    input  gtg_pkg::t_cordic  i_d,
    output logic              o_rdy,
    output logic              o_valid,
    output gtg_pkg::t_cordic  o_d,
    input  logic              i_rdy_next
);

    logic                         r_valid;
    gtg_pkg::t_cordic             r_d;
    gtg_pkg::t_cordic             n_d;
    logic signed [gtg_pkg::CW-1:0] w_xs;
    logic signed [gtg_pkg::CW-1:0] w_ys;
    logic [31:0]                  w_atan;
    logic                         w_y_pos;

    assign o_rdy   = !r_valid || i_rdy_next;
    assign o_valid = r_valid;
    assign o_d     = r_d;

    // One vectoring rotation: drive y toward zero, accumulate the angle.
    assign w_xs    = i_d.x >>> i_shift;
    assign w_ys    = i_d.y >>> i_shift;
    assign w_atan  = gtg_pkg::f_atan(i_shift);
    assign w_y_pos = !i_d.y[gtg_pkg::CW-1] && (i_d.y != '0);

    always_comb begin
        n_d = i_d;
        if (w_y_pos) begin
            n_d.x = i_d.x + w_ys;
            n_d.y = i_d.y - w_xs;
            n_d.z = i_d.z + w_atan;
        end else begin
            n_d.x = i_d.x - w_ys;
            n_d.y = i_d.y + w_xs;
            n_d.z = i_d.z - w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_d <= n_d;
        end
    end

endmodule

### rtl/gtg_back.sv
module gtg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gtg_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    input  gtg_pkg::t_cordic   i_d,
    output logic               o_rdy,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_drive_mode,
    output logic [15:0]        o_linear_speed,
    output logic signed [15:0] o_angular_speed,
    output logic [31:0]        o_goal_distance,
    output logic signed [15:0] o_heading_error
);

    logic [4:0]  r_v;
    logic [4:0]  w_rdy;

    // Stage 1: magnitude product and heading error.
    logic [58:0] r1_prod;
    logic [15:0] r1_err;
    logic [34:0] w_mag;
    logic [31:0] w_zeff;
    logic [31:0] w_bsum;
    logic [58:0] n1_prod;
    logic [15:0] n1_err;

    // Stage 2: rounded, saturated distance and absolute error.
    logic [31:0] r2_dist;
    logic [15:0] r2_err;
    logic [15:0] r2_abs;
    logic        r2_arr;
    logic [59:0] w_dsum;
    logic [31:0] n2_dist;

    // Stage 3: first products of both speed formulas.
    logic [31:0] r3_angp;
    logic [47:0] r3_linp;
    logic        r3_turn;
    logic        r3_arr;
    logic [31:0] r3_dist;
    logic [15:0] r3_err;

    // Stage 4: angular product by pi, linear speed clamped.
    logic [49:0] r4_angp;
    logic [15:0] r4_lin;
    logic        r4_turn;
    logic        r4_arr;
    logic [31:0] r4_dist;
    logic [15:0] r4_err;
    logic [48:0] w_lsum;
    logic [15:0] n4_lin;

    // Output stage.
    logic [1:0]         r_mode;
    logic [15:0]        r_lin;
    logic signed [15:0] r_ang;
    logic [31:0]        r_dist;
    logic [15:0]        r_err;
    logic [50:0]        w_asum;
    logic [23:0]        w_as;
    logic [14:0]        w_asc;
    logic [1:0]         n_mode;
    logic [15:0]        n_lin;
    logic signed [15:0] n_ang;

    // Stage handshake: a stage loads when it is empty or its content moves on.
    assign w_rdy[4] = !r_v[4] || !i_stall;
    assign w_rdy[3] = !r_v[3] || w_rdy[4];
    assign w_rdy[2] = !r_v[2] || w_rdy[3];
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_rdy    = w_rdy[0];
    assign o_valid  = r_v[4];

    // Stage 1 logic.
    assign w_mag   = (!i_d.x[gtg_pkg::CW-1] && (i_d.x != '0)) ? i_d.x[34:0] : '0;
    assign n1_prod = 59'(w_mag) * 59'(gtg_pkg::INV_GAIN_Q24);
    assign w_zeff  = i_d.zero ? 32'h0 : i_d.z;
    assign w_bsum  = w_zeff + 32'h00008000;
    assign n1_err  = w_bsum[31:16] - i_d.yaw;

    // Stage 2 logic.
    assign w_dsum  = 60'(r1_prod) + 60'h0000000_0080_0000;
    assign n2_dist = (w_dsum[59:56] != '0) ? 32'hFFFFFFFF : w_dsum[55:24];

    // Stage 4 logic: round, then raise to the minimum or cut to the maximum.
    assign w_lsum = 49'(r3_linp) + 49'd128;
    always_comb begin
        if (w_lsum[48:8] < 41'(gtg_pkg::MIN_LINEAR_SPEED)) begin
            n4_lin = gtg_pkg::MIN_LINEAR_SPEED;
        end else if (w_lsum[48:8] > 41'(i_cfg.max_linear)) begin
            n4_lin = i_cfg.max_linear;
        end else begin
            n4_lin = w_lsum[23:8];
        end
    end

    // Output stage logic: angular rounding, clamp, sign and mode selection.
    assign w_asum = 51'(r4_angp) + 51'h0000_0400_0000;
    assign w_as   = w_asum[50:27];
    always_comb begin
        if (w_as < 24'(gtg_pkg::MIN_ANGULAR_SPEED)) begin
            w_asc = gtg_pkg::MIN_ANGULAR_SPEED;
        end else if (w_as > 24'(i_cfg.max_angular)) begin
            w_asc = i_cfg.max_angular;
        end else begin
            w_asc = w_as[14:0];
        end
        n_lin = '0;
        n_ang = '0;
        if (r4_arr) begin
            n_mode = gtg_pkg::MODE_ARRIVED;
        end else if (r4_turn) begin
            n_mode = gtg_pkg::MODE_TURN;
            n_ang  = r4_err[15] ? -16'(w_asc) : 16'(w_asc);
        end else begin
            n_mode = gtg_pkg::MODE_DRIVE;
            n_lin  = r4_lin;
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_v[1] <= r_v[0];
            end
            if (w_rdy[2]) begin
                r_v[2] <= r_v[1];
            end
            if (w_rdy[3]) begin
                r_v[3] <= r_v[2];
            end
            if (w_rdy[4]) begin
                r_v[4] <= r_v[3];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_prod <= n1_prod;
            r1_err  <= n1_err;
        end
        if (w_rdy[1]) begin
            r2_dist <= n2_dist;
            r2_err  <= r1_err;
            r2_abs  <= r1_err[15] ? -r1_err : r1_err;
            r2_arr  <= n2_dist <= 32'(i_cfg.goal_tolerance);
        end
        if (w_rdy[2]) begin
            r3_angp <= 32'(i_cfg.yaw_gain) * 32'(r2_abs);
            r3_linp <= 48'(i_cfg.distance_gain) * 48'(r2_dist);
            r3_turn <= r2_abs > 16'(i_cfg.heading_tolerance);
            r3_arr  <= r2_arr;
            r3_dist <= r2_dist;
            r3_err  <= r2_err;
        end
        if (w_rdy[3]) begin
            r4_angp <= 50'(r3_angp) * 50'(gtg_pkg::PI_Q16);
            r4_lin  <= n4_lin;
            r4_turn <= r3_turn;
            r4_arr  <= r3_arr;
            r4_dist <= r3_dist;
            r4_err  <= r3_err;
        end
        if (w_rdy[4]) begin
            r_mode <= n_mode;
            r_lin  <= n_lin;
            r_ang  <= n_ang;
            r_dist <= r4_dist;
            r_err  <= r4_err;
        end
    end

    assign o_drive_mode    = r_mode;
    assign o_linear_speed  = r_lin;
    assign o_angular_speed = r_ang;
    assign o_goal_distance = r_dist;
    assign o_heading_error = r_err;

    // An arrived item carries no motion command.
    a_arrived_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && r_mode == gtg_pkg::MODE_ARRIVED) |-> (r_lin == '0 && r_ang == '0))
        else $error("arrived item with nonzero speed");

    // Turning in place never commands forward speed.
    a_turn_no_lin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && r_mode == gtg_pkg::MODE_TURN) |-> (r_lin == '0))
        else $error("turning item with forward speed");

    // Driving forward never commands a turn.
    a_drive_no_ang: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && r_mode == gtg_pkg::MODE_DRIVE) |-> (r_ang == '0))
        else $error("driving item with angular speed");

endmodule

### test/drive_cmd_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port of the go-to-goal controller.
// Each accepted pose item is turned into the drive command the block must
// produce, and each command that leaves the block is compared with the
// oldest one still waiting.
module drive_cmd_checker
    import gtg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_pose_valid,
    input  logic               i_pose_stall,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic signed [15:0] i_pose_yaw,
    input  logic               i_cmd_valid,
    input  logic               i_cmd_stall,
    input  logic [1:0]         i_drive_mode,
    input  logic [15:0]        i_linear_speed,
    input  logic signed [15:0] i_angular_speed,
    input  logic [31:0]        i_goal_distance,
    input  logic signed [15:0] i_heading_error,
    output int                 o_fail_count,
    output int                 o_cmds_waiting
);

    localparam int                ROTATIONS       = 16;
    localparam longint unsigned   INV_CORDIC_GAIN = 64'd10188014;
    localparam longint unsigned   PI_FIX          = 64'd205887;
    localparam longint unsigned   LIN_FLOOR       = 64'd1638;
    localparam longint unsigned   ANG_FLOOR       = 64'd328;
    localparam int                REPORT_LIMIT    = 10;

    // Arctangent of 2^-k for each rotation, a full turn being 2^32.
    localparam logic [0:15][31:0] ARCTAN_STEP = {
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] lin;
        logic [15:0] ang;
        logic [31:0] gdist;
        logic [15:0] herr;
    } drive_cmd_t;

    // Local copy of the register file.
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic [15:0]        arrive_tol;
    logic [14:0]        aim_tol;
    logic [15:0]        dist_gain;
    logic [15:0]        turn_gain;
    logic [15:0]        lin_cap;
    logic [14:0]        ang_cap;

    drive_cmd_t cmds_due[$];
    int         fails = 0;

    // Raise a speed to the floor first; only otherwise cut it to the cap.
    function automatic longint unsigned bound_speed(input longint unsigned spd,
                                                    input longint unsigned floor_v,
                                                    input longint unsigned cap_v);
        if (spd < floor_v) begin
            return floor_v;
        end
        if (spd > cap_v) begin
            return cap_v;
        end
        return spd;
    endfunction

    function automatic drive_cmd_t predict_drive_cmd(input logic signed [31:0] px,
                                                     input logic signed [31:0] py,
                                                     input logic [15:0] yaw);
        drive_cmd_t        cmd;
        longint            ox;
        longint            oy;
        longint            sx;
        longint            sy;
        logic [31:0]       bearing;
        logic [31:0]       rounded;
        longint unsigned   mag;
        longint unsigned   dist_q;
        longint unsigned   spd;
        longint unsigned   gain;
        logic [15:0]       err16;
        logic [15:0]       spd16;
        longint unsigned   abs_err;

        ox = longint'(goal_x) - longint'(px);
        oy = longint'(goal_y) - longint'(py);
        bearing = 32'h0;

        // Fold the left half plane onto the right one.
        if (ox < 0) begin
            ox = -ox;
            oy = -oy;
            bearing = 32'h8000_0000;
        end

        // Vectoring rotations drive the y component to zero.
        if (ox == 0 && oy == 0) begin
            bearing = 32'h0;
        end else begin
            for (int k = 0; k < ROTATIONS; k++) begin
                sx = ox >>> k;
                sy = oy >>> k;
                if (oy > 0) begin
                    ox = ox + sy;
                    oy = oy - sx;
                    bearing = bearing + ARCTAN_STEP[k];
                end else begin
                    ox = ox - sy;
                    oy = oy + sx;
                    bearing = bearing - ARCTAN_STEP[k];
                end
            end
        end

        // Remove the CORDIC gain and saturate the distance.
        mag = (ox > 0) ? longint'(ox) : 64'd0;
        dist_q = (mag * INV_CORDIC_GAIN + 64'd8388608) >> 24;
        if (dist_q > 64'hFFFF_FFFF) begin
            dist_q = 64'hFFFF_FFFF;
        end

        rounded = bearing + 32'h8000;
        err16 = rounded[31:16] - yaw;
        abs_err = err16[15] ? (64'd65536 - 64'(err16)) : {48'd0, err16};

        cmd = '0;
        cmd.gdist = dist_q[31:0];
        cmd.herr = err16;
        if (dist_q <= 64'(arrive_tol)) begin
            cmd.mode = MODE_ARRIVED;
        end else if (abs_err > 64'(aim_tol)) begin
            gain = 64'(turn_gain);
            spd = (gain * abs_err * PI_FIX + 64'd67108864) >> 27;
            spd = bound_speed(spd, ANG_FLOOR, 64'(ang_cap));
            spd16 = spd[15:0];
            cmd.mode = MODE_TURN;
            cmd.ang = err16[15] ? -spd16 : spd16;
        end else begin
            gain = 64'(dist_gain);
            spd = (gain * dist_q + 64'd128) >> 8;
            spd = bound_speed(spd, LIN_FLOOR, 64'(lin_cap));
            cmd.mode = MODE_DRIVE;
            cmd.lin = spd[15:0];
        end
        return cmd;
    endfunction

    always @(posedge i_clk) begin : watch
        drive_cmd_t want;
        drive_cmd_t got;

        if (!i_rst_n) begin
            cmds_due.delete();
            goal_x     <= 32'sd0;
            goal_y     <= 32'sd0;
            arrive_tol <= 16'd1638;
            aim_tol    <= 15'd365;
            dist_gain  <= 16'd115;
            turn_gain  <= 16'd384;
            lin_cap    <= 16'd11796;
            ang_cap    <= 15'd3277;
        end else begin
            // Register writes take effect at the same edge as in the block.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TARGET_X:          goal_x     <= i_cfg_data;
                    REG_TARGET_Y:          goal_y     <= i_cfg_data;
                    REG_GOAL_TOLERANCE:    arrive_tol <= i_cfg_data[15:0];
                    REG_HEADING_TOLERANCE: aim_tol    <= i_cfg_data[14:0];
                    REG_DISTANCE_GAIN:     dist_gain  <= i_cfg_data[15:0];
                    REG_YAW_GAIN:          turn_gain  <= i_cfg_data[15:0];
                    REG_MAX_LINEAR:        lin_cap    <= i_cfg_data[15:0];
                    REG_MAX_ANGULAR:       ang_cap    <= i_cfg_data[14:0];
                    default: ;
                endcase
            end

            // Compare before queuing, so a command never meets its own pose.
            if (i_cmd_valid && !i_cmd_stall) begin
                got = {i_drive_mode, i_linear_speed, i_angular_speed, i_goal_distance,
                       i_heading_error};
                if (cmds_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT) begin
                        $display("%0t: unexpected command mode %0d lin %0d ang %0d",
                                 $realtime, got.mode, got.lin, $signed(got.ang));
                        $display("  dist %0d err %0d", got.gdist, $signed(got.herr));
                    end
                end else begin
                    want = cmds_due.pop_front();
                    if (want.mode !== got.mode || want.lin !== got.lin ||
                        want.ang !== got.ang || want.gdist !== got.gdist ||
                        want.herr !== got.herr) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("%0t: command mismatch", $realtime);
                            $display("  expected mode %0d lin %0d ang %0d dist %0d err %0d",
                                     want.mode, want.lin, $signed(want.ang), want.gdist,
                                     $signed(want.herr));
                            $display("  actual   mode %0d lin %0d ang %0d dist %0d err %0d",
                                     got.mode, got.lin, $signed(got.ang), got.gdist,
                                     $signed(got.herr));
                        end
                    end
                end
            end

            if (i_pose_valid && !i_pose_stall) begin
                cmds_due.push_back(predict_drive_cmd(i_pose_x, i_pose_y, i_pose_yaw));
            end
        end
        o_fail_count   <= fails;
        o_cmds_waiting <= cmds_due.size();
    end

endmodule

### test/tb_go_to_goal_rotate_then_drive.sv
`timescale 1ns / 1ps

module tb_go_to_goal_rotate_then_drive;
    import gtg_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 2;
    localparam int QUIET_LIMIT      = 4000;
    localparam int HOLD_CYCLES      = 200;
    localparam int DRAIN_CYCLES     = 40;
    localparam int PHASES           = 3;
    localparam int BLOCKS_PER_PHASE = 6;
    localparam int POSES_PER_BLOCK  = 96;
    localparam int METER            = 65536;
    localparam real PI_REAL         = 3.14159265358979;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = REG_TARGET_X;
    logic [31:0]        i_cfg_data = 32'd0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_pose_x = 32'sd0;
    logic signed [31:0] i_pose_y = 32'sd0;
    logic signed [15:0] i_pose_yaw = 16'sd0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_drive_mode;
    logic [15:0]        o_linear_speed;
    logic signed [15:0] o_angular_speed;
    logic [31:0]        o_goal_distance;
    logic signed [15:0] o_heading_error;

    int   send_idle_pct = 27;
    int   recv_idle_pct = 46;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   fail_count;
    int   cmds_waiting;

    // Settings as last written, used to aim the random poses.
    logic [31:0]        reg_vals [8];
    logic signed [31:0] goal_x = 32'sd0;
    logic signed [31:0] goal_y = 32'sd0;
    logic [15:0]        arrive_tol = 16'd1638;
    logic [14:0]        aim_tol = 15'd365;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    go_to_goal_rotate_then_drive dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pose_x        (i_pose_x),
        .i_pose_y        (i_pose_y),
        .i_pose_yaw      (i_pose_yaw),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_drive_mode    (o_drive_mode),
        .o_linear_speed  (o_linear_speed),
        .o_angular_speed (o_angular_speed),
        .o_goal_distance (o_goal_distance),
        .o_heading_error (o_heading_error)
    );

    drive_cmd_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_pose_valid    (i_valid),
        .i_pose_stall    (o_stall),
        .i_pose_x        (i_pose_x),
        .i_pose_y        (i_pose_y),
        .i_pose_yaw      (i_pose_yaw),
        .i_cmd_valid     (o_valid),
        .i_cmd_stall     (i_stall),
        .i_drive_mode    (o_drive_mode),
        .i_linear_speed  (o_linear_speed),
        .i_angular_speed (o_angular_speed),
        .i_goal_distance (o_goal_distance),
        .i_heading_error (o_heading_error),
        .o_fail_count    (fail_count),
        .o_cmds_waiting  (cmds_waiting)
    );

    // Command side: random stalls, plus one long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: too long without any item moving on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offer one pose item and return at the edge where it is accepted.
    task automatic send_pose(input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic signed [15:0] yaw);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pose_x   <= px;
        i_pose_y   <= py;
        i_pose_yaw <= yaw;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    // Stop offering and wait until every predicted command has come out.
    task automatic settle();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (cmds_waiting != 0);
    endtask

    // Write all eight registers on consecutive cycles; call only while idle.
    task automatic set_all(input logic [31:0] tx, input logic [31:0] ty,
                           input logic [31:0] gt, input logic [31:0] ht,
                           input logic [31:0] dg, input logic [31:0] yg,
                           input logic [31:0] ml, input logic [31:0] ma);
        int r;
        reg_vals[REG_TARGET_X]          = tx;
        reg_vals[REG_TARGET_Y]          = ty;
        reg_vals[REG_GOAL_TOLERANCE]    = gt;
        reg_vals[REG_HEADING_TOLERANCE] = ht;
        reg_vals[REG_DISTANCE_GAIN]     = dg;
        reg_vals[REG_YAW_GAIN]          = yg;
        reg_vals[REG_MAX_LINEAR]        = ml;
        reg_vals[REG_MAX_ANGULAR]       = ma;
        goal_x     = tx;
        goal_y     = ty;
        arrive_tol = gt[15:0];
        aim_tol    = ht[14:0];
        for (r = REG_TARGET_X; r <= REG_MAX_ANGULAR; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(r);
            i_cfg_data <= reg_vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Random register value that often lands on zero, the top, or a small number.
    function automatic int unsigned spread(input int unsigned top);
        case ($urandom_range(7))
            0:       return 0;
            1:       return top;
            2, 3:    return $urandom_range(top / 64);
            default: return $urandom_range(top);
        endcase
    endfunction

    // New settings; the narrow registers get random bits above their width.
    task automatic pick_settings();
        logic [31:0] tx;
        logic [31:0] ty;
        tx = ($urandom_range(9) < 7) ? 32'(int'($urandom_range(1 << 23)) - (1 << 22))
                                     : $urandom();
        ty = ($urandom_range(9) < 7) ? 32'(int'($urandom_range(1 << 23)) - (1 << 22))
                                     : $urandom();
        set_all(tx, ty,
                {16'($urandom()), 16'(spread(65535))},
                {17'($urandom()), 15'(spread(32767))},
                {16'($urandom()), 16'(spread(65535))},
                {16'($urandom()), 16'(spread(65535))},
                {16'($urandom()), 16'(spread(65535))},
                {17'($urandom()), 15'(spread(32767))});
    endtask

    // Mostly poses around the goal, half of them headed roughly at it.
    task automatic send_random_pose();
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] yaw;
        longint             reach;
        int unsigned        pick;
        real                aim;
        pick = $urandom_range(99);
        if (pick < 10) begin
            px  = $urandom();
            py  = $urandom();
            yaw = 16'($urandom());
        end else begin
            if (pick < 40) begin
                reach = 2 * longint'(arrive_tol) + 64;
            end else if (pick < 75) begin
                reach = longint'(1 << 20);
            end else begin
                reach = longint'(1 << 27);
            end
            px = 32'(longint'(goal_x) + longint'($urandom_range(32'(2 * reach))) - reach);
            py = 32'(longint'(goal_y) + longint'($urandom_range(32'(2 * reach))) - reach);
            if ($urandom_range(1) == 1) begin
                aim = $atan2(real'(longint'(goal_y) - longint'(py)),
                             real'(longint'(goal_x) - longint'(px)));
                yaw = 16'($rtoi(aim * 32768.0 / PI_REAL) + int'($urandom_range(2 * aim_tol + 16))
                          - int'(aim_tol) - 8);
            end else begin
                yaw = 16'($urandom());
            end
        end
        send_pose(px, py, yaw);
    endtask

    initial begin
        reg_vals[REG_TARGET_X]          = 32'd0;
        reg_vals[REG_TARGET_Y]          = 32'd0;
        reg_vals[REG_GOAL_TOLERANCE]    = 32'd1638;
        reg_vals[REG_HEADING_TOLERANCE] = 32'd365;
        reg_vals[REG_DISTANCE_GAIN]     = 32'd115;
        reg_vals[REG_YAW_GAIN]          = 32'd384;
        reg_vals[REG_MAX_LINEAR]        = 32'd11796;
        reg_vals[REG_MAX_ANGULAR]       = 32'd3277;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Settings after reset: arrival, both turn directions, clamps, wrap at pi.
        send_pose(32'sd0, 32'sd0, 16'sd0);
        send_pose(-100 * METER, 32'sd0, 16'sh8000);
        send_pose(-100 * METER, 32'sd0, 16'sd0);
        send_pose(-32'sd6553, 32'sd0, 16'sd0);
        send_pose(-32'sd2000, 32'sd0, 16'sd0);
        send_pose(-100 * METER, 32'sd0, 16'sd400);
        send_pose(-100 * METER, 32'sd0, -16'sd8192);
        send_pose(100 * METER, 32'sd0, 16'sd0);
        send_pose(32'sd0, 100 * METER, 16'sd16384);
        send_pose(32'sd0, -100 * METER, 16'sd16384);
        send_pose(-32'sd1000, 32'sd0, 16'sd0);
        send_pose(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF);
        send_pose(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000);

        // Every register at its top: saturated distance and speeds.
        settle();
        set_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65535, 32'd32767,
                32'd65535, 32'd65535, 32'd65535, 32'd32767);
        send_pose(32'sh8000_0000, 32'sh8000_0000, 16'sd0);
        send_pose(32'sh8000_0000, 32'sh8000_0000, -16'sd24576);
        send_pose(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sd0);

        // Every register at zero: speeds fall back to the floors.
        settle();
        set_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_pose(32'sd0, 32'sd0, 16'sd0);
        send_pose(-32'sd1, 32'sd0, 16'sd0);
        send_pose(-1000 * METER, 5 * METER, 16'sd5000);
        send_pose(32'sd0, -32'sd1, 16'sd0);

        // Caps below the floors with large gains: the caps win.
        settle();
        set_all(32'd0, 32'd0, 32'd1638, 32'd365, 32'd65535, 32'd65535, 32'd100, 32'd10);
        send_pose(-100 * METER, 32'sd0, 16'sd0);
        send_pose(-100 * METER, 32'sd0, -16'sd8192);

        // Random part in three idling phases, new settings for every block.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                send_idle_pct = 27;
                recv_idle_pct <= 46;
            end else if (phase == 1) begin
                send_idle_pct = 46;
                recv_idle_pct <= 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
                settle();
                pick_settings();
                // Long hold-off on the command side so the pipeline fills up.
                if (phase == 0 && blk == 0) begin
                    hold_req <= 1'b1;
                end
                for (int n = 0; n < POSES_PER_BLOCK; n++) begin
                    send_random_pose();
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/gtg_pkg.sv
rtl/gtg_front.sv
rtl/gtg_cell.sv
rtl/gtg_back.sv
rtl/go_to_goal_rotate_then_drive.sv
test/drive_cmd_checker.sv
test/tb_go_to_goal_rotate_then_drive.sv
